// ----- rtl/real_quadratic_root_solver_core_macros.svh -----
// Assertion macros for the quadratic root solver.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef REAL_QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define REAL_QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
// Plain property check, disabled during reset.
`define RQRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication check, disabled during reset.
`define RQRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ----- rtl/rqrs_pkg.sv -----
// Shared types and constants for the quadratic root solver.
// No dependencies.
package rqrs_pkg;

  localparam int unsigned COEF_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SQRT_RAD_W    = 68;
  localparam int unsigned SQRT_ROOT_W   = SQRT_RAD_W / 2;
  localparam int unsigned DIV_DEN_W     = 34;

  localparam logic [1:0] CNT_COMPLEX  = 2'd0;
  localparam logic [1:0] CNT_DOUBLE   = 2'd1;
  localparam logic [1:0] CNT_DISTINCT = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_const;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_square;
  } req_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] root_first;
    logic signed [COEF_W-1:0] root_second;
    logic [1:0]               real_root_count;
    logic                     saturated;
    logic                     degenerate;
  } res_t;

  // Sideband carried along the square root chain.
  typedef struct packed {
    logic              n0;
    logic              n1;
    logic              n2;
    logic [COEF_W-1:0] m0;
    logic [COEF_W-1:0] m1;
    logic [COEF_W-1:0] m2;
    logic              dneg;
    logic              dzero;
    logic              deg;
  } sq_sb_t;

  // Sideband carried along the divider chain.
  typedef struct packed {
    logic       sign1;
    logic       sign2;
    logic [1:0] cnt;
    logic       deg;
  } dv_sb_t;

endpackage

// ----- rtl/rqrs_sqrt_cell.sv -----
// One digit cell of the pipelined floor square root: one result bit per cell.
// No package dependencies.
module rqrs_sqrt_cell #(
  parameter int unsigned RAD_W = 68,
  parameter int unsigned SB_W  = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [RAD_W-1:0]       rad_i,
  input  logic [RAD_W/2:0]       rem_i,
  input  logic [RAD_W/2-1:0]     root_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   valid_o,
  output logic [RAD_W-1:0]       rad_o,
  output logic [RAD_W/2:0]       rem_o,
  output logic [RAD_W/2-1:0]     root_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 1;

  logic [REM_W+1:0]  remx;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;
  logic [REM_W-1:0]  rem_d;
  logic [ROOT_W-1:0] root_d;
  logic [RAD_W-1:0]  rad_d;
  logic              valid_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SB_W-1:0]   sb_q;

  // Bring down the next radicand pair and try root*4+1.
  always_comb begin
    remx   = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = remx - trial;
    ge     = remx >= trial;
    rem_d  = ge ? diff[REM_W-1:0] : remx[REM_W-1:0];
    root_d = {root_i[ROOT_W-2:0], ge};
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sb_q   <= sb_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign sb_o    = sb_q;

endmodule

// ----- rtl/rqrs_div_cell.sv -----
// One quotient-bit cell of the two-lane pipelined restoring divider.
// No package dependencies.
module rqrs_div_cell #(
  parameter int unsigned NUM_W = 50,
  parameter int unsigned DEN_W = 34,
  parameter int unsigned SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i [2],
  input  logic [DEN_W-1:0] rem_i [2],
  input  logic [NUM_W-1:0] quo_i [2],
  input  logic [DEN_W-1:0] den_i [2],
  input  logic [SB_W-1:0]  sb_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] num_o [2],
  output logic [DEN_W-1:0] rem_o [2],
  output logic [NUM_W-1:0] quo_o [2],
  output logic [DEN_W-1:0] den_o [2],
  output logic [SB_W-1:0]  sb_o
);

  logic [DEN_W:0]   remx  [2];
  logic [DEN_W:0]   diff  [2];
  logic             ge    [2];
  logic [DEN_W-1:0] rem_d [2];
  logic [NUM_W-1:0] quo_d [2];
  logic [NUM_W-1:0] num_d [2];
  logic             valid_q;
  logic [SB_W-1:0]  sb_q;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      remx[k]  = {rem_i[k], num_i[k][NUM_W-1]};
      diff[k]  = remx[k] - {1'b0, den_i[k]};
      ge[k]    = remx[k] >= {1'b0, den_i[k]};
      rem_d[k] = ge[k] ? diff[k][DEN_W-1:0] : remx[k][DEN_W-1:0];
      quo_d[k] = {quo_i[k][NUM_W-2:0], ge[k]};
      num_d[k] = {num_i[k][NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      num_o[k] <= num_d[k];
      rem_o[k] <= rem_d[k];
      quo_o[k] <= quo_d[k];
      den_o[k] <= den_i[k];
    end
    sb_q <= sb_i;
  end

  assign valid_o = valid_q;
  assign sb_o    = sb_q;

endmodule

// ----- rtl/real_quadratic_root_solver_core.sv -----
// Roots are signed fixed point with FRAC_BITS fraction bits (Q16.16 at the default).
// Throughput: one coefficient set per cycle; busy stays low, the receiver cannot stall.
// Latency is set by the 34-cell square root chain and the (34 + FRAC_BITS)-cell divider.
// Reset: asynchronous active low, clears every valid bit; nothing else needs clearing.
// Depends on rqrs_pkg, rqrs_sqrt_cell, rqrs_div_cell and the assertion macro header.
`include "real_quadratic_root_solver_core_macros.svh"
module real_quadratic_root_solver_core #(
  parameter int unsigned FRAC_BITS = rqrs_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rqrs_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output rqrs_pkg::res_t res_o
);

  import rqrs_pkg::*;

  localparam int unsigned NUM_W   = SQRT_ROOT_W + FRAC_BITS;
  localparam int unsigned SQ_SB_W = $bits(sq_sb_t);
  localparam int unsigned DV_SB_W = $bits(dv_sb_t);
  localparam int unsigned LATENCY = SQRT_ROOT_W + NUM_W + 5;
  localparam int unsigned PROD_W  = 2 * COEF_W;
  localparam int unsigned DISC_W  = PROD_W + 2;

  // ---------------------------------------------------------------------------
  // Stage 1: split each coefficient into sign and magnitude.
  // ---------------------------------------------------------------------------
  logic              v1_q;
  logic              n0_q, n1_q, n2_q;
  logic [COEF_W-1:0] m0_q, m1_q, m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q <= req_i.coef_const[COEF_W-1];
    n1_q <= req_i.coef_linear[COEF_W-1];
    n2_q <= req_i.coef_square[COEF_W-1];
    m0_q <= req_i.coef_const[COEF_W-1]  ? -req_i.coef_const  : req_i.coef_const;
    m1_q <= req_i.coef_linear[COEF_W-1] ? -req_i.coef_linear : req_i.coef_linear;
    m2_q <= req_i.coef_square[COEF_W-1] ? -req_i.coef_square : req_i.coef_square;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the two discriminant products, one multiplier each.
  // ---------------------------------------------------------------------------
  logic              v2_q;
  logic [PROD_W-1:0] p_q, m_q;
  sq_sb_t            sb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= m1_q * m1_q;
    m_q         <= m0_q * m2_q;
    sb2_q.n0    <= n0_q;
    sb2_q.n1    <= n1_q;
    sb2_q.n2    <= n2_q;
    sb2_q.m0    <= m0_q;
    sb2_q.m1    <= m1_q;
    sb2_q.m2    <= m2_q;
    sb2_q.dneg  <= 1'b0;
    sb2_q.dzero <= 1'b0;
    sb2_q.deg   <= (m2_q == '0);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: discriminant magnitude and sign, d = a1^2 - 4 a2 a0.
  // ---------------------------------------------------------------------------
  logic              v3_q;
  logic [DISC_W-1:0] pe, four, dmag_d, dmag_q;
  logic              dneg_d;
  logic              same_sign;
  sq_sb_t            sb3_d;
  sq_sb_t            sb3_q;

  always_comb begin
    pe        = DISC_W'(p_q);
    four      = {m_q, 2'b00};
    same_sign = (sb2_q.n0 == sb2_q.n2) && (sb2_q.m0 != '0);
    dneg_d    = 1'b0;
    if (same_sign) begin
      if (pe >= four) begin
        dmag_d = pe - four;
      end else begin
        dneg_d = 1'b1;
        dmag_d = four - pe;
      end
    end else begin
      dmag_d = pe + four;
    end
    sb3_d      = sb2_q;
    sb3_d.dneg = dneg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dmag_q <= dmag_d;
    sb3_q  <= sb3_d;
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one result bit per cell, MSB first.
  // ---------------------------------------------------------------------------
  logic                   sq_v    [SQRT_ROOT_W+1];
  logic [SQRT_RAD_W-1:0]  sq_rad  [SQRT_ROOT_W+1];
  logic [SQRT_ROOT_W:0]   sq_rem  [SQRT_ROOT_W+1];
  logic [SQRT_ROOT_W-1:0] sq_root [SQRT_ROOT_W+1];
  logic [SQ_SB_W-1:0]     sq_sb   [SQRT_ROOT_W+1];
  sq_sb_t                 sb_in;

  always_comb begin
    sb_in       = sb3_q;
    sb_in.dzero = (dmag_q == '0);
  end

  assign sq_v[0]    = v3_q;
  assign sq_rad[0]  = SQRT_RAD_W'(dmag_q);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = sb_in;

  for (genvar i = 0; i < SQRT_ROOT_W; i++) begin : g_sqrt
    rqrs_sqrt_cell #(
      .RAD_W (SQRT_RAD_W),
      .SB_W  (SQ_SB_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .sb_i    (sq_sb[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .sb_o    (sq_sb[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Select stage: pick dividends, divisors and result signs per case.
  // Complex: m1/den and s/den. Double: m1/den twice. Distinct: q2/den, 2 m0/q2.
  // ---------------------------------------------------------------------------
  sq_sb_t                 sq_out;
  logic [SQRT_ROOT_W-1:0] s_root;
  logic [SQRT_ROOT_W:0]   q2_wide;
  logic [DIV_DEN_W-1:0]   q2, den;
  logic [NUM_W-1:0]       num_d [2];
  logic [DIV_DEN_W-1:0]   dsr_d [2];
  dv_sb_t                 dsb_d;

  always_comb begin
    sq_out    = sq_sb[SQRT_ROOT_W];
    s_root    = sq_root[SQRT_ROOT_W];
    q2_wide   = (SQRT_ROOT_W+1)'(sq_out.m1) + (SQRT_ROOT_W+1)'(s_root);
    q2        = q2_wide[DIV_DEN_W-1:0];
    den       = {1'b0, sq_out.m2, 1'b0};
    dsb_d.deg = sq_out.deg;
    dsb_d.sign1 = (!sq_out.n1) ^ sq_out.n2;
    num_d[0]  = NUM_W'(sq_out.m1) << FRAC_BITS;
    dsr_d[0]  = den;
    num_d[1]  = NUM_W'(sq_out.m1) << FRAC_BITS;
    dsr_d[1]  = den;
    dsb_d.sign2 = dsb_d.sign1;
    if (sq_out.dneg) begin
      dsb_d.cnt = CNT_COMPLEX;
      num_d[1]  = NUM_W'(s_root) << FRAC_BITS;
    end else if (sq_out.dzero) begin
      dsb_d.cnt = CNT_DOUBLE;
    end else begin
      dsb_d.cnt   = CNT_DISTINCT;
      num_d[0]    = NUM_W'(q2) << FRAC_BITS;
      num_d[1]    = NUM_W'(sq_out.m0) << (FRAC_BITS + 1);
      dsr_d[1]    = q2;
      dsb_d.sign2 = sq_out.n0 ^ (!sq_out.n1);
    end
  end

  logic                 dv_v   [NUM_W+1];
  logic [NUM_W-1:0]     dv_num [NUM_W+1][2];
  logic [DIV_DEN_W-1:0] dv_rem [NUM_W+1][2];
  logic [NUM_W-1:0]     dv_quo [NUM_W+1][2];
  logic [DIV_DEN_W-1:0] dv_den [NUM_W+1][2];
  logic [DV_SB_W-1:0]   dv_sb  [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[SQRT_ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      dv_num[0][k] <= num_d[k];
      dv_den[0][k] <= dsr_d[k];
      dv_rem[0][k] <= '0;
      dv_quo[0][k] <= '0;
    end
    dv_sb[0] <= dsb_d;
  end

  // ---------------------------------------------------------------------------
  // Divider chain: both lanes advance one quotient bit per cell.
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    rqrs_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (DIV_DEN_W),
      .SB_W  (DV_SB_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .num_i   (dv_num[j]),
      .rem_i   (dv_rem[j]),
      .quo_i   (dv_quo[j]),
      .den_i   (dv_den[j]),
      .sb_i    (dv_sb[j]),
      .valid_o (dv_v[j+1]),
      .num_o   (dv_num[j+1]),
      .rem_o   (dv_rem[j+1]),
      .quo_o   (dv_quo[j+1]),
      .den_o   (dv_den[j+1]),
      .sb_o    (dv_sb[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: apply signs, saturate to the 32-bit range, drop on a2 = 0.
  // ---------------------------------------------------------------------------
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({1'b0, {(COEF_W-1){1'b1}}});
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'({1'b1, {(COEF_W-1){1'b0}}});

  dv_sb_t            osb;
  logic [COEF_W-1:0] root_v [2];
  logic              sat_v  [2];
  logic              sgn_v  [2];
  res_t              res_d;
  logic              done_q;
  res_t              res_q;

  always_comb begin
    osb      = dv_sb[NUM_W];
    sgn_v[0] = osb.sign1;
    sgn_v[1] = osb.sign2;
    for (int k = 0; k < 2; k++) begin
      if (sgn_v[k]) begin
        sat_v[k]  = dv_quo[NUM_W][k] > NEG_LIM;
        root_v[k] = sat_v[k] ? NEG_LIM[COEF_W-1:0] : -dv_quo[NUM_W][k][COEF_W-1:0];
      end else begin
        sat_v[k]  = dv_quo[NUM_W][k] > POS_LIM;
        root_v[k] = sat_v[k] ? POS_LIM[COEF_W-1:0] : dv_quo[NUM_W][k][COEF_W-1:0];
      end
    end
    if (osb.deg) begin
      res_d.root_first      = '0;
      res_d.root_second     = '0;
      res_d.real_root_count = CNT_COMPLEX;
      res_d.saturated       = 1'b0;
      res_d.degenerate      = 1'b1;
    end else begin
      res_d.root_first      = root_v[0];
      res_d.root_second     = root_v[1];
      res_d.real_root_count = osb.cnt;
      res_d.saturated       = sat_v[0] | sat_v[1];
      res_d.degenerate      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Every stage moves each cycle, so a new request is always taken.
  assign busy   = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

  `RQRS_ASSERT_IMP(a_fixed_latency, start, ##LATENCY done_o, "result missing at fixed latency")
  `RQRS_ASSERT_IMP(a_count_code, done_o, res_o.real_root_count != 2'd3, "bad root count code")
  `RQRS_ASSERT_IMP(a_double_equal, done_o && res_o.real_root_count == CNT_DOUBLE,
                   res_o.root_first == res_o.root_second, "double root outputs differ")
  `RQRS_ASSERT_IMP(a_degenerate_zero, done_o && res_o.degenerate,
                   res_o.root_first == '0 && res_o.root_second == '0 && !res_o.saturated,
                   "degenerate result not cleared")
  `RQRS_ASSERT(a_never_busy, !busy, "busy raised")

endmodule
